@@ sv/assert_macros.svh @@
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FCPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcpd check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define FCPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcpd check failed");

`endif

@@ sv/fcpd_pkg.sv @@
package fcpd_pkg;

    localparam int CAP_W  = 11;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd256;

    // register word indexes
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7f;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_ESCAPE = 2'd1,
        ST_CONTROL    = 2'd2,
        ST_OVERFLOW   = 2'd3
    } status_t;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66)
            || (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            v = b - 8'h30;
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            v = b - 8'h57;
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            v = b - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

@@ sv/fcpd_in_if.sv @@
interface fcpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink   (input valid, input in_byte, input last, output ready);
endinterface

@@ sv/fcpd_out_if.sv @@
interface fcpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    logic [1:0] status;

    modport source (output valid, output out_byte, output byte_valid, output done_res,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input done_res,
                    input status, output ready);
endinterface

@@ sv/form_component_percent_decoder.sv @@
// a request accepted into the input register passes the combinational decode step and
// is loaded into the result register, which drives dec, once that register is free
// throughput: one encoded byte per cycle while dec does not stall; the decode step
// between the input register and the result register is combinational
// reset: rst_n low clears decode state, both pipeline valids and sets capacity to 256
// bytes that produce nothing (escape digits, swallowed bytes) leave no result
module form_component_percent_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fcpd_pkg::ADDR_W-1:0] paddr,
    input  logic [fcpd_pkg::DATA_W-1:0] pwdata,
    output logic [fcpd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    fcpd_in_if.sink                     enc,
    fcpd_out_if.source                  dec
);
    import fcpd_pkg::*;

    // escape tracking: plain byte, first hex digit, second hex digit
    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_HI    = 2'd1,
        PH_LO    = 2'd2
    } phase_t;

    // configuration
    logic [CAP_W-1:0] cap_reg;
    logic             cfg_wr;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // decode state
    phase_t           phase_reg, phase_next;
    logic [3:0]       hi_reg, hi_next;
    logic [CAP_W-1:0] cnt_reg, cnt_next;
    status_t          err_reg, err_next, err_step;

    // result register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_bv_reg;
    logic       out_done_reg;
    status_t    out_status_reg;

    // decode step signals
    logic           emit;
    logic           chk;
    logic [7:0]     ch;
    logic [CAP_W:0] cnt_inc;
    logic           overflow;
    logic           has_result;
    logic           out_free;
    logic           s1_adv;
    logic           s1_fire;
    logic           in_fire;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_CAPACITY);
    assign prdata = (paddr[ADDR_W-1] == REG_CAPACITY)
                    ? {{(DATA_W-CAP_W){1'b0}}, cap_reg} : '0;

    // the input register drains whenever it holds no result or the result has somewhere to go
    assign out_free   = !out_valid_reg || dec.ready;
    assign s1_adv     = !has_result || out_free;
    assign s1_fire    = s1_valid_reg && s1_adv;
    assign enc.ready  = !s1_valid_reg || s1_adv;
    assign in_fire    = enc.valid && enc.ready;

    assign cnt_inc  = {1'b0, cnt_reg} + {{CAP_W{1'b0}}, 1'b1};
    assign overflow = cnt_inc >= {1'b0, cap_reg};

    always_comb
    begin
        phase_next = phase_reg;
        hi_next    = hi_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        emit       = 1'b0;
        chk        = 1'b0;
        ch         = s1_byte_reg;
        if (err_reg == ST_OK)
        begin
            unique case (phase_reg)
                PH_HI:
                begin
                    // a first digit arriving last is a truncated escape
                    if (!is_hex(s1_byte_reg) || s1_last_reg)
                    begin
                        err_next = ST_BAD_ESCAPE;
                    end
                    else
                    begin
                        hi_next    = hex_val(s1_byte_reg);
                        phase_next = PH_LO;
                    end
                end
                PH_LO:
                begin
                    phase_next = PH_PLAIN;
                    ch         = {hi_reg, hex_val(s1_byte_reg)};
                    // a zero escape counts as a bad escape
                    if (!is_hex(s1_byte_reg) || ch == 8'h00)
                    begin
                        err_next = ST_BAD_ESCAPE;
                    end
                    else
                    begin
                        chk = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_PLAIN;
                    if (s1_byte_reg == CH_PERCENT)
                    begin
                        if (s1_last_reg)
                        begin
                            err_next = ST_BAD_ESCAPE;
                        end
                        else
                        begin
                            phase_next = PH_HI;
                        end
                    end
                    else
                    begin
                        ch  = (s1_byte_reg == CH_PLUS) ? CH_SPACE : s1_byte_reg;
                        chk = 1'b1;
                    end
                end
            endcase
            // control check goes ahead of the capacity check
            if (chk)
            begin
                if (ch < CH_SPACE || ch == CH_DEL)
                begin
                    err_next = ST_CONTROL;
                end
                else if (overflow)
                begin
                    err_next = ST_OVERFLOW;
                end
                else
                begin
                    emit     = 1'b1;
                    cnt_next = cnt_inc[CAP_W-1:0];
                end
            end
        end
        err_step = err_next;
        // the last byte closes the component and clears the decode state
        if (s1_last_reg)
        begin
            phase_next = PH_PLAIN;
            hi_next    = 4'h0;
            cnt_next   = '0;
            err_next   = ST_OK;
        end
    end

    assign has_result = emit || s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_RESET;
            s1_valid_reg   <= 1'b0;
            s1_byte_reg    <= 8'h00;
            s1_last_reg    <= 1'b0;
            phase_reg      <= PH_PLAIN;
            hi_reg         <= 4'h0;
            cnt_reg        <= '0;
            err_reg        <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= 8'h00;
            out_bv_reg     <= 1'b0;
            out_done_reg   <= 1'b0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            if (cfg_wr)
            begin
                cap_reg <= pwdata[CAP_W-1:0];
            end

            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                s1_byte_reg  <= enc.in_byte;
                s1_last_reg  <= enc.last;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                phase_reg <= phase_next;
                hi_reg    <= hi_next;
                cnt_reg   <= cnt_next;
                err_reg   <= err_next;
            end

            if (s1_fire && has_result)
            begin
                out_valid_reg  <= 1'b1;
                out_byte_reg   <= emit ? ch : 8'h00;
                out_bv_reg     <= emit;
                out_done_reg   <= s1_last_reg;
                out_status_reg <= s1_last_reg ? err_step : ST_OK;
            end
            else if (dec.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign dec.valid      = out_valid_reg;
    assign dec.out_byte   = out_byte_reg;
    assign dec.byte_valid = out_bv_reg;
    assign dec.done_res   = out_done_reg;
    assign dec.status     = out_status_reg;

endmodule

@@ sv/fcpd_checker.sv @@
`include "assert_macros.svh"

module fcpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       dec_valid,
    input logic       dec_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       done_res,
    input logic [1:0] status
);
    import fcpd_pkg::*;

    // a stalled result keeps its contents
    `FCPD_ASSERT_NEXT(a_hold, dec_valid && !dec_ready, dec_valid && $stable(out_byte) && $stable(byte_valid) && $stable(done_res) && $stable(status))
    // every result carries a byte or closes a component
    `FCPD_ASSERT_NOW(a_nonempty, dec_valid, byte_valid || done_res)
    // status only reported on the closing result
    `FCPD_ASSERT_NOW(a_status, dec_valid && !done_res, status == ST_OK)
    // decoded bytes are never control characters, and absent bytes read zero
    `FCPD_ASSERT_NOW(a_byte, dec_valid, byte_valid ? (out_byte >= CH_SPACE && out_byte != CH_DEL) : (out_byte == 8'h00))

endmodule

bind form_component_percent_decoder fcpd_checker u_fcpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .dec_valid  (dec.valid),
    .dec_ready  (dec.ready),
    .out_byte   (dec.out_byte),
    .byte_valid (dec.byte_valid),
    .done_res   (dec.done_res),
    .status     (dec.status)
);
